>>> hw/rtl/espnf_pkg.sv
// shared types and constants for the expiring slot pool with next-fit search
`timescale 1ns / 1ps
`default_nettype none

package espnf_pkg;

    // pool geometry
    localparam int SLOTS  = 64;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // life values, unsigned Q1.15
    localparam int LIFE_W = 16;
    localparam logic [LIFE_W-1:0] LIFE_ONE  = 16'h8000;
    localparam logic [LIFE_W-1:0] LIFE_ZERO = 16'h0000;

    // decay arithmetic: Q4.12 rate times Q0.16 time, shifted down to Q1.15
    localparam int RATE_W        = 16;
    localparam int DT_W          = 16;
    localparam int PROD_W        = RATE_W + DT_W;
    localparam int PRODUCT_SHIFT = 13;
    localparam int DEC_W         = PROD_W - PRODUCT_SHIFT;
    localparam logic [RATE_W-1:0] DECAY_RESET = 16'd410;

    // result field widths
    localparam int IDX_W = 6;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_FADE_RATE = 1'b0;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // input transaction
    typedef struct packed {
        logic            opcode;
        logic [DT_W-1:0] step_time;
    } in_t;

    // result transaction
    typedef struct packed {
        logic [IDX_W-1:0] slot_index;
        logic             overwrote;
    } out_t;

endpackage

`default_nettype wire

>>> hw/rtl/expiring_slot_pool_next_fit.sv
// expiring slot pool: next-fit slot allocation with per-tick life decay
// allocate: the life memory is scanned from the search position, one read per cycle
//   while the output register has room; tick: one memory read per slot and a write
//   back of each slot that is not free
// throughput: one transaction at a time, s_ready is high only between items
// reset: synchronous active-low; all slots free, search position 0, rate register 410
`timescale 1ns / 1ps
`default_nettype none

module expiring_slot_pool_next_fit (
    input  wire                          aclk,
    input  wire                          aresetn,
    // input transactions
    input  wire                          s_valid,
    output logic                         s_ready,
    input  espnf_pkg::in_t               s_data,
    // result transactions
    output logic                         m_valid,
    input  wire                          m_ready,
    output espnf_pkg::out_t              m_data,
    // configuration port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [espnf_pkg::PADDR_W-1:0] paddr,
    input  wire [espnf_pkg::PDATA_W-1:0] pwdata,
    output logic [espnf_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TICK = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    logic [espnf_pkg::RATE_W-1:0]      fade_rate_reg;
    logic [espnf_pkg::SLOT_W-1:0]      start_reg;
    logic [espnf_pkg::DEC_W-1:0]       dec_reg;
    logic [espnf_pkg::SLOT_W-1:0]      iss_addr_reg;
    logic [espnf_pkg::CNT_W-1:0]       iss_cnt_reg;
    logic                              chk_vld_reg;
    logic                              chk_last_reg;
    logic [espnf_pkg::SLOT_W-1:0]      chk_addr_reg;
    logic                              m_valid_reg;
    espnf_pkg::out_t                   m_data_reg;

    // life memory and its per-entry written flags
    logic [espnf_pkg::LIFE_W-1:0]      mem [espnf_pkg::SLOTS];
    logic [espnf_pkg::SLOTS-1:0]       written_reg;
    logic [espnf_pkg::LIFE_W-1:0]      rd_data_reg;
    logic                              rd_written_reg;

    logic                              accept;
    logic                              cfg_hit;
    logic                              out_free;
    logic                              issue;
    logic                              more;
    logic [espnf_pkg::SLOT_W-1:0]      iss_addr_inc;
    logic [espnf_pkg::LIFE_W-1:0]      life;
    logic                              slot_free;
    logic [espnf_pkg::PROD_W-1:0]      product;
    logic [espnf_pkg::LIFE_W-1:0]      life_decayed;
    logic                              mem_we;
    logic [espnf_pkg::SLOT_W-1:0]      mem_waddr;
    logic [espnf_pkg::LIFE_W-1:0]      mem_wdata;
    logic                              scan_hit;
    logic                              scan_full;

    // handshakes and configuration decode
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign cfg_hit  = (paddr[espnf_pkg::PADDR_W-1:2] == espnf_pkg::REG_FADE_RATE);
    assign pready   = 1'b1;
    assign prdata   = cfg_hit ? espnf_pkg::PDATA_W'(fade_rate_reg) : '0;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // decrement for a tick, computed as the item is taken
    assign product = espnf_pkg::PROD_W'(fade_rate_reg) * espnf_pkg::PROD_W'(s_data.step_time);

    // value of the entry just read; never-written entries read as free
    assign life      = rd_written_reg ? rd_data_reg : espnf_pkg::LIFE_ZERO;
    assign slot_free = (life == espnf_pkg::LIFE_ZERO);

    // saturating decay of one slot
    always_comb begin
        if (espnf_pkg::DEC_W'(life) <= dec_reg) begin
            life_decayed = espnf_pkg::LIFE_ZERO;
        end else begin
            life_decayed = life - dec_reg[espnf_pkg::LIFE_W-1:0];
        end
    end

    // next read address with wrap
    assign iss_addr_inc = (iss_addr_reg == espnf_pkg::SLOT_W'(espnf_pkg::SLOTS - 1))
                          ? '0 : iss_addr_reg + 1'b1;
    assign more = (iss_cnt_reg != espnf_pkg::CNT_W'(espnf_pkg::SLOTS));

    // scan outcome for the entry under check
    assign scan_hit  = (state_reg == ST_SCAN) && chk_vld_reg && out_free && slot_free;
    assign scan_full = (state_reg == ST_SCAN) && chk_vld_reg && out_free && !slot_free
                       && chk_last_reg;

    // read issue: ticks never stall, scans wait for room in the output register
    always_comb begin
        unique case (state_reg)
            ST_TICK: issue = more;
            ST_SCAN: issue = more && out_free;
            default: issue = 1'b0;
        endcase
    end

    // memory write port
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = chk_addr_reg;
        mem_wdata = life_decayed;
        if (state_reg == ST_TICK && chk_vld_reg && !slot_free) begin
            mem_we = 1'b1;
        end else if (scan_hit) begin
            mem_we    = 1'b1;
            mem_wdata = espnf_pkg::LIFE_ONE;
        end else if (scan_full) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = espnf_pkg::LIFE_ONE;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_data.opcode == espnf_pkg::OP_TICK) ? ST_TICK : ST_SCAN;
                end
            end
            ST_TICK: begin
                if (chk_vld_reg && chk_last_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_hit || scan_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // memory array, synchronous read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            rd_data_reg <= mem[iss_addr_reg];
        end
    end

    // written flags and the read-side copy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (mem_we) begin
                written_reg[mem_waddr] <= 1'b1;
            end
            if (issue) begin
                rd_written_reg <= written_reg[iss_addr_reg];
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fade_rate_reg  <= espnf_pkg::DECAY_RESET;
            start_reg      <= '0;
            iss_cnt_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (psel && penable && pwrite && cfg_hit) begin
                fade_rate_reg <= pwdata[espnf_pkg::RATE_W-1:0];
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                iss_cnt_reg <= '0;
                chk_vld_reg <= 1'b0;
            end else if (issue) begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
                chk_vld_reg <= 1'b1;
            end else if (state_reg == ST_TICK) begin
                chk_vld_reg <= 1'b0;
            end
            if (scan_hit) begin
                start_reg   <= chk_addr_reg;
                m_valid_reg <= 1'b1;
            end else if (scan_full) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            dec_reg      <= product[espnf_pkg::PROD_W-1:espnf_pkg::PRODUCT_SHIFT];
            iss_addr_reg <= (s_data.opcode == espnf_pkg::OP_TICK) ? '0 : start_reg;
        end else if (issue) begin
            iss_addr_reg <= iss_addr_inc;
        end
        if (issue) begin
            chk_addr_reg <= iss_addr_reg;
            chk_last_reg <= (iss_cnt_reg == espnf_pkg::CNT_W'(espnf_pkg::SLOTS - 1));
        end
        if (scan_hit) begin
            m_data_reg.slot_index <= espnf_pkg::IDX_W'(chk_addr_reg);
            m_data_reg.overwrote  <= 1'b0;
        end else if (scan_full) begin
            m_data_reg.slot_index <= '0;
            m_data_reg.overwrote  <= 1'b1;
        end
    end

endmodule

`default_nettype wire
